// ===== design/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int KEEP_W = 12;
  localparam logic [KEEP_W-1:0] KEEP_LIMIT_RST = 12'd1023;

  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       last;
  } result_t;

endpackage

// ===== design/wsdf_parser.sv =====
// Frame header and payload parser: holds the frame state and forms at most one result per byte.
module wsdf_parser #(
  parameter int LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [7:0]                  in_byte,
  input  logic [wsdf_pkg::KEEP_W-1:0] keep_limit,
  output wsdf_pkg::result_t           result
);

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  wsdf_pkg::phase_t       phase, phase_next;
  logic [3:0]             frame_opcode, frame_opcode_next;
  logic                   is_masked, is_masked_next;
  logic [3:0]             header_bytes_left, header_bytes_left_next;
  logic [LENGTH_BITS-1:0] frame_length, frame_length_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [LENGTH_BITS-1:0] payload_index, payload_index_next;

  logic                   length_done;
  logic                   header_done;
  logic [LENGTH_BITS-1:0] len_val;
  logic                   masked_val;
  logic [LENGTH_BITS-1:0] keep_ext;
  logic [LENGTH_BITS-1:0] kept;
  logic [LENGTH_BITS-1:0] idx_inc;
  logic [7:0]             key_byte;

  assign keep_ext = {{(LENGTH_BITS-wsdf_pkg::KEEP_W){1'b0}}, keep_limit};
  assign kept = (frame_length < keep_ext) ? frame_length : keep_ext;
  assign idx_inc = payload_index + LEN_ONE;

  always_comb begin
    case (payload_index[1:0])
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next = phase;
    frame_opcode_next = frame_opcode;
    is_masked_next = is_masked;
    header_bytes_left_next = header_bytes_left;
    frame_length_next = frame_length;
    mask_key_next = mask_key;
    payload_index_next = payload_index;
    length_done = 1'b0;
    header_done = 1'b0;
    len_val = frame_length;
    masked_val = is_masked;
    result = '0;

    unique case (phase)
      wsdf_pkg::PH_HDR1: begin
        is_masked_next = in_byte[7];
        masked_val = in_byte[7];
        mask_key_next = '0;
        frame_length_next = '0;
        if (in_byte[6:0] == wsdf_pkg::LEN7_EXT16 ||
            in_byte[6:0] == wsdf_pkg::LEN7_EXT64) begin
          header_bytes_left_next = (in_byte[6:0] == wsdf_pkg::LEN7_EXT16) ?
                                   wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
          phase_next = wsdf_pkg::PH_EXTLEN;
        end else begin
          len_val = {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]};
          frame_length_next = len_val;
          length_done = 1'b1;
        end
      end
      wsdf_pkg::PH_EXTLEN: begin
        len_val = {frame_length[LENGTH_BITS-9:0], in_byte};
        frame_length_next = len_val;
        header_bytes_left_next = header_bytes_left - 4'd1;
        length_done = (header_bytes_left_next == 4'd0);
      end
      wsdf_pkg::PH_MASK: begin
        mask_key_next = {mask_key[23:0], in_byte};
        header_bytes_left_next = header_bytes_left - 4'd1;
        header_done = (header_bytes_left_next == 4'd0);
      end
      wsdf_pkg::PH_PAYLOAD: begin
        payload_index_next = idx_inc;
        if (idx_inc >= frame_length) begin
          phase_next = wsdf_pkg::PH_HDR0;
        end
        if (frame_opcode != wsdf_pkg::OPC_CLOSE && payload_index < kept) begin
          result.valid = 1'b1;
          result.kind = wsdf_pkg::KIND_DATA;
          result.payload_byte = is_masked ? (in_byte ^ key_byte) : in_byte;
          result.last = (idx_inc == kept);
        end
      end
      default: begin
        frame_opcode_next = in_byte[3:0];
        phase_next = wsdf_pkg::PH_HDR1;
      end
    endcase

    if (length_done) begin
      if (masked_val) begin
        header_bytes_left_next = wsdf_pkg::MASK_BYTES;
        phase_next = wsdf_pkg::PH_MASK;
      end else begin
        header_done = 1'b1;
      end
    end

    if (header_done) begin
      payload_index_next = '0;
      phase_next = (len_val != '0) ? wsdf_pkg::PH_PAYLOAD : wsdf_pkg::PH_HDR0;
      if (frame_opcode == wsdf_pkg::OPC_CLOSE) begin
        result.valid = 1'b1;
        result.kind = wsdf_pkg::KIND_CLOSE;
        result.last = 1'b1;
      end else if (len_val == '0 || keep_limit == '0) begin
        result.valid = 1'b1;
        result.kind = wsdf_pkg::KIND_EMPTY;
        result.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wsdf_pkg::PH_HDR0;
      frame_opcode <= '0;
      is_masked <= 1'b0;
      header_bytes_left <= '0;
      frame_length <= '0;
      mask_key <= '0;
      payload_index <= '0;
    end else if (step) begin
      phase <= phase_next;
      frame_opcode <= frame_opcode_next;
      is_masked <= is_masked_next;
      header_bytes_left <= header_bytes_left_next;
      frame_length <= frame_length_next;
      mask_key <= mask_key_next;
      payload_index <= payload_index_next;
    end
  end

endmodule

// ===== design/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: input register, parser and result register.
// The block takes one stream byte per clock while the output side is ready: each accepted
// byte is held in an input register, parsed by the header and payload logic, and any result
// is stored in an output register from which it is presented. A new byte can still be taken
// into the empty input register while a result waits to be read.
// Frame lengths are kept to LENGTH_BITS bits; keep_limit is written through cfg_wr_en and
// cfg_wr_data and should be changed only while no result is outstanding.
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // in_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // payload_byte
  output logic                        m_axis_tlast,
  output logic [1:0]                  m_axis_tuser,  // kind
  input  logic                        cfg_wr_en,
  input  logic [wsdf_pkg::KEEP_W-1:0] cfg_wr_data
);

  logic [wsdf_pkg::KEEP_W-1:0] keep_limit;
  logic                        in_valid;
  logic [7:0]                  in_data;
  logic                        advance;
  wsdf_pkg::result_t           result;
  wsdf_pkg::result_t           out_reg;

  assign advance = in_valid && (!out_reg.valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= wsdf_pkg::KEEP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      keep_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
  end

  wsdf_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .in_byte    (in_data),
    .keep_limit (keep_limit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg <= '0;
    end else if (advance) begin
      out_reg <= result;
    end else if (m_axis_tready) begin
      out_reg.valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_reg.valid;
  assign m_axis_tdata = out_reg.payload_byte;
  assign m_axis_tlast = out_reg.last;
  assign m_axis_tuser = out_reg.kind;

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != wsdf_pkg::KIND_DATA) |->
      (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("Empty or close result without last or with nonzero data.");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_data)))
    else $error("Held input byte was lost or changed while stalled.");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_reg.valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("Input taken while both stages are blocked.");

endmodule

// ===== bench/wsdf_stream_checker.sv =====
// Checker for the WebSocket frame deframer: tracks requests, predicts results and compares.
`timescale 1ns / 1ps

module wsdf_stream_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_valid,
  input  logic                        s_ready,
  input  logic [7:0]                  s_data,
  input  logic                        m_valid,
  input  logic                        m_ready,
  input  logic [7:0]                  m_data,
  input  logic                        m_last,
  input  logic [1:0]                  m_user,
  input  logic                        cfg_en,
  input  logic [wsdf_pkg::KEEP_W-1:0] cfg_data,
  input  logic                        end_check,
  output int                          fail_count,
  output int                          pending,
  output int                          n_data,
  output int                          n_empty,
  output int                          n_close
);

  typedef struct packed {
    wsdf_pkg::kind_t kind;
    logic [7:0]      data;
    logic            last;
  } deframed_t;

  deframed_t exp_q[$];
  int errors = 0;
  bit end_done = 1'b0;

  wsdf_pkg::phase_t            ph;
  logic [3:0]                  frm_opc;
  logic                        frm_masked;
  logic [3:0]                  hdr_left;
  logic [63:0]                 frm_len;
  logic [31:0]                 mkey;
  logic [63:0]                 pay_idx;
  logic [wsdf_pkg::KEEP_W-1:0] keep_lim;

  assign fail_count = errors;

  task automatic report_fail(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function automatic bit header_complete(output deframed_t r);
    pay_idx = '0;
    ph = (frm_len != 0) ? wsdf_pkg::PH_PAYLOAD : wsdf_pkg::PH_HDR0;
    r = '{kind: wsdf_pkg::KIND_DATA, data: 8'h00, last: 1'b1};
    if (frm_opc == wsdf_pkg::OPC_CLOSE) begin
      r.kind = wsdf_pkg::KIND_CLOSE;
      return 1'b1;
    end
    if (frm_len == 0 || keep_lim == 0) begin
      r.kind = wsdf_pkg::KIND_EMPTY;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit length_known(output deframed_t r);
    r = '{kind: wsdf_pkg::KIND_DATA, data: 8'h00, last: 1'b0};
    if (frm_masked) begin
      hdr_left = wsdf_pkg::MASK_BYTES;
      ph = wsdf_pkg::PH_MASK;
      return 1'b0;
    end
    return header_complete(r);
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output deframed_t r);
    logic [63:0] kept;
    logic [63:0] idx;
    int          sh;
    bit          hit;
    r = '{kind: wsdf_pkg::KIND_DATA, data: 8'h00, last: 1'b0};
    hit = 1'b0;
    case (ph)
      wsdf_pkg::PH_HDR1: begin
        frm_masked = b[7];
        mkey = '0;
        frm_len = '0;
        if (b[6:0] == wsdf_pkg::LEN7_EXT16 || b[6:0] == wsdf_pkg::LEN7_EXT64) begin
          hdr_left = (b[6:0] == wsdf_pkg::LEN7_EXT16) ? wsdf_pkg::EXT16_BYTES :
                                                        wsdf_pkg::EXT64_BYTES;
          ph = wsdf_pkg::PH_EXTLEN;
        end else begin
          frm_len = {57'd0, b[6:0]};
          hit = length_known(r);
        end
      end
      wsdf_pkg::PH_EXTLEN: begin
        frm_len = {frm_len[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) hit = length_known(r);
      end
      wsdf_pkg::PH_MASK: begin
        mkey = {mkey[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) hit = header_complete(r);
      end
      wsdf_pkg::PH_PAYLOAD: begin
        idx = pay_idx;
        kept = (frm_len < {52'd0, keep_lim}) ? frm_len : {52'd0, keep_lim};
        pay_idx = idx + 64'd1;
        if (pay_idx >= frm_len) ph = wsdf_pkg::PH_HDR0;
        if (frm_opc != wsdf_pkg::OPC_CLOSE && idx < kept) begin
          sh = 24 - 8 * int'(idx[1:0]);
          r.data = frm_masked ? (b ^ 8'(mkey >> sh)) : b;
          r.last = (idx + 64'd1 == kept);
          hit = 1'b1;
        end
      end
      default: begin
        frm_opc = b[3:0];
        ph = wsdf_pkg::PH_HDR1;
      end
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin
    deframed_t got;
    deframed_t want;
    deframed_t pred;
    if (rst) begin
      ph = wsdf_pkg::PH_HDR0;
      frm_opc = '0;
      frm_masked = 1'b0;
      hdr_left = '0;
      frm_len = '0;
      mkey = '0;
      pay_idx = '0;
      keep_lim = wsdf_pkg::KEEP_LIMIT_RST;
      exp_q.delete();
      pending <= 0;
      n_data <= 0;
      n_empty <= 0;
      n_close <= 0;
    end else begin
      if (m_valid && m_ready) begin
        got.kind = wsdf_pkg::kind_t'(m_user);
        got.data = m_data;
        got.last = m_last;
        if (exp_q.size() == 0) begin
          report_fail($sformatf("result with nothing expected: kind %0d byte %02h last %0b",
                                m_user, m_data, m_last));
        end else begin
          want = exp_q.pop_front();
          if (got.kind != want.kind)
            report_fail($sformatf("kind %0d, expected %0d", m_user, want.kind));
          if (got.data != want.data)
            report_fail($sformatf("payload byte %02h, expected %02h", got.data, want.data));
          if (got.last != want.last)
            report_fail($sformatf("last %0b, expected %0b", got.last, want.last));
        end
        case (m_user)
          wsdf_pkg::KIND_DATA:  n_data <= n_data + 1;
          wsdf_pkg::KIND_EMPTY: n_empty <= n_empty + 1;
          default:              n_close <= n_close + 1;
        endcase
      end
      if (cfg_en) keep_lim = cfg_data;
      if (s_valid && s_ready) begin
        if (parse_byte(s_data, pred)) exp_q.push_back(pred);
      end
      if (end_check && !end_done) begin
        if (exp_q.size() != 0)
          report_fail($sformatf("%0d expected results never arrived", exp_q.size()));
        end_done = 1'b1;
      end
      pending <= exp_q.size();
    end
  end

endmodule

// ===== bench/websocket_frame_deframer_tb.sv =====
// Testbench top for the WebSocket frame deframer: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

  localparam int ENC_NATURAL = 0;
  localparam int ENC_16 = 1;
  localparam int ENC_64 = 2;
  localparam int QUIET_LIMIT = 4000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata = 8'h00;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [7:0]                  m_axis_tdata;
  logic                        m_axis_tlast;
  logic [1:0]                  m_axis_tuser;
  logic                        cfg_wr_en = 1'b0;
  logic [wsdf_pkg::KEEP_W-1:0] cfg_wr_data = '0;
  logic                        end_check = 1'b0;

  int fail_count;
  int pending;
  int n_data;
  int n_empty;
  int n_close;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int quiet = 0;
  int keep_now = 1023;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  websocket_frame_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  wsdf_stream_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_data    (s_axis_tdata),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (m_axis_tdata),
    .m_last    (m_axis_tlast),
    .m_user    (m_axis_tuser),
    .cfg_en    (cfg_wr_en),
    .cfg_data  (cfg_wr_data),
    .end_check (end_check),
    .fail_count(fail_count),
    .pending   (pending),
    .n_data    (n_data),
    .n_empty   (n_empty),
    .n_close   (n_close)
  );

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no request accepted for %0d cycles.", QUIET_LIMIT);
      $display("websocket_frame_deframer_tb NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_keep_limit(input int value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[wsdf_pkg::KEEP_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    keep_now = value;
  endtask

  task automatic send_frame(input logic [3:0] flags, input logic [3:0] opc, input bit masked,
                            input logic [63:0] len, input int enc, input logic [31:0] key,
                            input int n_send, input bit use_fill);
    logic [6:0] len7;
    len7 = (enc == ENC_16) ? wsdf_pkg::LEN7_EXT16 :
           (enc == ENC_64) ? wsdf_pkg::LEN7_EXT64 : len[6:0];
    send_byte({flags, opc});
    send_byte({masked, len7});
    if (enc == ENC_16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (enc == ENC_64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    for (int i = 0; i < n_send; i++)
      send_byte(use_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom));
    frames_sent++;
  endtask

  task automatic random_frame();
    logic [3:0]  opc;
    logic [63:0] len;
    int          enc;
    int          pick;
    opc = ($urandom_range(0, 99) < 20) ? wsdf_pkg::OPC_CLOSE : 4'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) len = 64'd0;
    else if (pick < 25 && keep_now >= 1 && keep_now <= 300)
      len = 64'(keep_now - 1 + int'($urandom_range(0, 2)));
    else if (pick < 70) len = 64'($urandom_range(1, 12));
    else if (pick < 90) len = 64'($urandom_range(13, 125));
    else len = 64'($urandom_range(126, 300));
    pick = $urandom_range(0, 99);
    if (len >= 126) enc = (pick < 80) ? ENC_16 : ENC_64;
    else enc = (pick < 80) ? ENC_NATURAL : (pick < 90) ? ENC_16 : ENC_64;
    send_frame(4'($urandom), opc, 1'($urandom_range(0, 1)), len, enc, $urandom, int'(len),
               1'b0);
  endtask

  initial begin
    int keep_seq[6];
    int start;
    keep_seq = '{3, 0, 4095, 1, 0, 1023};
    keep_seq[4] = $urandom_range(2, 40);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(4'hF, 4'h1, 1'b0, 64'd0, ENC_NATURAL, 32'h0, 0, 1'b0);
    send_frame(4'h0, 4'h2, 1'b1, 64'd3, ENC_NATURAL, 32'hA5C3_0FF0, 3, 1'b1);
    send_frame(4'h8, wsdf_pkg::OPC_CLOSE, 1'b0, 64'd2, ENC_NATURAL, 32'h0, 2, 1'b0);
    send_frame(4'h0, 4'h0, 1'b0, 64'd0, ENC_16, 32'h0, 0, 1'b0);
    send_frame(4'h4, 4'hA, 1'b0, 64'd1, ENC_64, 32'h0, 1, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      set_keep_limit(keep_seq[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < 60) random_frame();
      wait_idle();
    end

    // Truncated frames and stray bytes leave the parser out of step with frame boundaries.
    set_keep_limit($urandom_range(0, 20));
    tx_idle_pct = 29;
    rx_stall_pct = 29;
    for (int i = 0; i < 15; i++) begin
      if ($urandom_range(0, 1))
        send_frame(4'($urandom), 4'($urandom), 1'($urandom_range(0, 1)), 64'd9, ENC_NATURAL,
                   $urandom, $urandom_range(0, 8), 1'b0);
      else
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
    send_frame(4'h0, 4'h2, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ENC_64, $urandom, 40, 1'b0);

    wait_idle();
    repeat (4) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    $display("Sent %0d stream bytes in %0d frames over four idle and stall mixes.",
             bytes_sent, frames_sent);
    $display("Results checked: %0d payload bytes, %0d empty messages, %0d close frames.",
             n_data, n_empty, n_close);
    if (fail_count == 0)
      $display("websocket_frame_deframer_tb OK");
    else
      $display("websocket_frame_deframer_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wsdf_pkg.sv
design/wsdf_parser.sv
design/websocket_frame_deframer.sv
bench/wsdf_stream_checker.sv
bench/websocket_frame_deframer_tb.sv
